[hdl/rfmp_pkg.sv]
package rfmp_pkg;

  localparam logic [7:0] PT_RTPFB = 8'd205;
  localparam logic [7:0] PT_PSFB  = 8'd206;

  localparam logic [4:0] FMT_NACK = 5'd1;
  localparam logic [4:0] FMT_PLI  = 5'd1;
  localparam logic [4:0] FMT_SLI  = 5'd2;
  localparam logic [4:0] FMT_RPSI = 5'd3;

  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_NACK    = 3'd1;
  localparam logic [2:0] KIND_PLI     = 3'd2;
  localparam logic [2:0] KIND_SLI     = 3'd3;
  localparam logic [2:0] KIND_RPSI    = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FB    = 2'd1;
  localparam logic [1:0] ST_TOO_SMALL = 2'd2;
  localparam logic [1:0] ST_TOO_BIG   = 2'd3;

  // work codes passed from front to back
  localparam logic [1:0] OP_DIRECT = 2'd0;
  localparam logic [1:0] OP_NACK   = 2'd1;
  localparam logic [1:0] OP_SLI    = 2'd2;
  localparam logic [1:0] OP_RPSI   = 2'd3;

  localparam logic [15:0] MAX_ENTRIES_RESET = 16'd64;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [15:0] cnt;
    logic        last;
    logic [31:0] word;
    logic [17:0] rpsi_bytes;
  } cmd_t;

endpackage

[hdl/rtcp_feedback_message_parser.sv]
// Path: a word that causes a result is written to the command queue at its
//   transfer edge and is then loaded into the output register once that register
//   is empty or its result is taken, and the result transfers out on result_ready.
// Throughput: one word per cycle; the header classifier and the field decode
//   each sit between two registers, so nothing iterates. Words stall only when
//   the queue holds QUEUE_DEPTH commands behind a result that is not taken.
// Reset (rst, synchronous): parser idle, queue empty, no result pending,
//   max_entries back to 64.
module rtcp_feedback_message_parser #(
  parameter int QUEUE_DEPTH = 2  // 2 or more
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: max_entries
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  // packet words
  input  logic        word_valid,
  output logic        word_ready,
  input  logic [31:0] packet_word,
  input  logic        is_first,
  input  logic [15:0] buffer_bytes,
  // results
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [1:0]  status,
  output logic [15:0] entry_count,
  output logic [15:0] nack_pid,
  output logic [15:0] nack_blp,
  output logic [12:0] sli_first,
  output logic [12:0] sli_number,
  output logic [5:0]  sli_picture_id,
  output logic [6:0]  rpsi_payload_type,
  output logic [20:0] rpsi_bit_length,
  output logic        is_last
);
  import rfmp_pkg::*;

  logic [15:0] max_entries;

  logic accept;
  logic push, full;
  logic q_valid, q_pop;
  logic q_pop_ready;
  cmd_t push_cmd, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= MAX_ENTRIES_RESET;
    end else if (cfg_write) begin
      max_entries <= cfg_data;
    end
  end

  // The front takes a word whenever the queue has room; a transfer that
  // yields no result (SSRC skip, idle words, passed RPSI header) never
  // writes the queue.
  assign word_ready = !full;
  assign accept     = word_valid && word_ready;

  // Front: header classification, size checks, SSRC skip and entry count.
  rfmp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .packet_word  (packet_word),
    .is_first     (is_first),
    .buffer_bytes (buffer_bytes),
    .max_entries  (max_entries),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Short queue decouples classification from result delivery.
  rfmp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  // Back: NACK/SLI field split, RPSI padding checks and bit length,
  // output register.
  rfmp_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cmd_valid         (q_valid),
    .cmd               (head),
    .cmd_ready         (q_pop_ready),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .kind              (kind),
    .status            (status),
    .entry_count       (entry_count),
    .nack_pid          (nack_pid),
    .nack_blp          (nack_blp),
    .sli_first         (sli_first),
    .sli_number        (sli_number),
    .sli_picture_id    (sli_picture_id),
    .rpsi_payload_type (rpsi_payload_type),
    .rpsi_bit_length   (rpsi_bit_length),
    .is_last           (is_last)
  );

  assign q_pop = q_valid && q_pop_ready;

endmodule

[hdl/rfmp_front.sv]
module rfmp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [31:0]   packet_word,
  input  logic          is_first,
  input  logic [15:0]   buffer_bytes,
  input  logic [15:0]   max_entries,
  output logic          push,
  output rfmp_pkg::cmd_t cmd
);
  import rfmp_pkg::*;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_SKIP_NACK = 3'd1;
  localparam logic [2:0] PH_SKIP_SLI  = 3'd2;
  localparam logic [2:0] PH_SKIP_RPSI = 3'd3;
  localparam logic [2:0] PH_NACK      = 3'd4;
  localparam logic [2:0] PH_SLI       = 3'd5;
  localparam logic [2:0] PH_RPSI      = 3'd6;

  logic [2:0]  phase, phase_next;
  logic [1:0]  ssrc_left, ssrc_left_next;
  logic [15:0] entries_left, entries_left_next;
  logic [15:0] entry_total, entry_total_next;
  logic [17:0] rpsi_bytes, rpsi_bytes_next;

  logic [4:0]  fmt;
  logic [7:0]  pt;
  logic [15:0] len, len_m2, n, et;
  logic [2:0]  hdr_kind;
  logic [18:0] need_list, need_rpsi, buf19;
  logic [1:0]  ssrc_dec;
  logic [15:0] entries_dec;

  assign fmt    = packet_word[28:24];
  assign pt     = packet_word[23:16];
  assign len    = packet_word[15:0];
  assign len_m2 = len - 16'd2;
  assign n      = (len > 16'd2) ? len_m2 : 16'd0;
  assign et     = (n < max_entries) ? n : max_entries;
  assign buf19  = {3'b000, buffer_bytes};
  // (n+3)*4 and (len-2)*4+12 == len*4+4
  assign need_list = {1'b0, n, 2'b00} + 19'd12;
  assign need_rpsi = {1'b0, len, 2'b00} + 19'd4;
  assign ssrc_dec    = (ssrc_left != 2'd0) ? ssrc_left - 2'd1 : 2'd0;
  assign entries_dec = (entries_left != 16'd0) ? entries_left - 16'd1 : 16'd0;

  always_comb begin
    if (pt == PT_RTPFB && fmt == FMT_NACK) hdr_kind = KIND_NACK;
    else if (pt == PT_PSFB && fmt == FMT_PLI) hdr_kind = KIND_PLI;
    else if (pt == PT_PSFB && fmt == FMT_SLI) hdr_kind = KIND_SLI;
    else if (pt == PT_PSFB && fmt == FMT_RPSI) hdr_kind = KIND_RPSI;
    else hdr_kind = KIND_UNKNOWN;
  end

  always_comb begin
    phase_next        = phase;
    ssrc_left_next    = ssrc_left;
    entries_left_next = entries_left;
    entry_total_next  = entry_total;
    rpsi_bytes_next   = rpsi_bytes;
    push              = 1'b0;
    cmd               = '0;
    cmd.op            = OP_DIRECT;
    cmd.word          = packet_word;
    cmd.last          = 1'b1;
    if (accept) begin
      if (is_first) begin
        phase_next        = PH_IDLE;
        ssrc_left_next    = 2'd0;
        entries_left_next = 16'd0;
        entry_total_next  = 16'd0;
        rpsi_bytes_next   = 18'd0;
        cmd.kind          = hdr_kind;
        if (buffer_bytes < 16'd12) begin
          push       = 1'b1;
          cmd.status = ST_TOO_SMALL;
        end else if (hdr_kind == KIND_UNKNOWN) begin
          push       = 1'b1;
          cmd.status = ST_NOT_FB;
        end else if (hdr_kind == KIND_PLI) begin
          push       = 1'b1;
          cmd.status = ST_OK;
        end else if (hdr_kind == KIND_RPSI) begin
          if (len < 16'd3 || buf19 < need_rpsi) begin
            push       = 1'b1;
            cmd.status = ST_TOO_SMALL;
          end else begin
            phase_next      = PH_SKIP_RPSI;
            ssrc_left_next  = 2'd2;
            rpsi_bytes_next = {len_m2, 2'b00};
          end
        end else if (buf19 < need_list) begin
          push       = 1'b1;
          cmd.status = ST_TOO_SMALL;
        end else begin
          push              = 1'b1;
          cmd.status        = ST_OK;
          cmd.cnt           = et;
          entry_total_next  = et;
          entries_left_next = et;
          if (et != 16'd0) begin
            cmd.last       = 1'b0;
            ssrc_left_next = 2'd2;
            phase_next     = (hdr_kind == KIND_NACK) ? PH_SKIP_NACK : PH_SKIP_SLI;
          end
        end
      end else begin
        unique case (phase)
          PH_SKIP_NACK, PH_SKIP_SLI, PH_SKIP_RPSI: begin
            ssrc_left_next = ssrc_dec;
            if (ssrc_dec == 2'd0) begin
              phase_next = phase + 3'd3;
            end
          end
          PH_NACK, PH_SLI: begin
            entries_left_next = entries_dec;
            push              = 1'b1;
            cmd.op            = (phase == PH_NACK) ? OP_NACK : OP_SLI;
            cmd.kind          = (phase == PH_NACK) ? KIND_NACK : KIND_SLI;
            cmd.status        = ST_OK;
            cmd.cnt           = entry_total;
            cmd.last          = (entries_dec == 16'd0);
            if (entries_dec == 16'd0) begin
              phase_next = PH_IDLE;
            end
          end
          PH_RPSI: begin
            phase_next     = PH_IDLE;
            push           = 1'b1;
            cmd.op         = OP_RPSI;
            cmd.kind       = KIND_RPSI;
            cmd.rpsi_bytes = rpsi_bytes;
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      ssrc_left    <= 2'd0;
      entries_left <= 16'd0;
      entry_total  <= 16'd0;
      rpsi_bytes   <= 18'd0;
    end else begin
      phase        <= phase_next;
      ssrc_left    <= ssrc_left_next;
      entries_left <= entries_left_next;
      entry_total  <= entry_total_next;
      rpsi_bytes   <= rpsi_bytes_next;
    end
  end

  // skip phases always have an SSRC word pending
  a_skip_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SKIP_NACK || phase == PH_SKIP_SLI || phase == PH_SKIP_RPSI)
      |-> ssrc_left != 2'd0)
    else $error("skip phase with no SSRC word left");

  // entry phases always have at least one entry to emit
  a_entries_pending: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_NACK || phase == PH_SLI) |-> entries_left != 16'd0)
    else $error("entry phase with no entry left");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries_left <= entry_total)
    else $error("entries left exceeds announced total");

endmodule

[hdl/rfmp_queue.sv]
module rfmp_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rfmp_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rfmp_pkg::cmd_t head
);
  import rfmp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("queue underflow");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count out of range");

endmodule

[hdl/rfmp_back.sv]
module rfmp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  rfmp_pkg::cmd_t cmd,
  output logic           cmd_ready,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [2:0]     kind,
  output logic [1:0]     status,
  output logic [15:0]    entry_count,
  output logic [15:0]    nack_pid,
  output logic [15:0]    nack_blp,
  output logic [12:0]    sli_first,
  output logic [12:0]    sli_number,
  output logic [5:0]     sli_picture_id,
  output logic [6:0]     rpsi_payload_type,
  output logic [20:0]    rpsi_bit_length,
  output logic           is_last
);
  import rfmp_pkg::*;

  logic        load;
  logic [7:0]  pad;
  logic [20:0] bits;
  logic [21:0] min_bits;

  logic [1:0]  status_next;
  logic [15:0] pid_next, blp_next;
  logic [12:0] first_next, number_next;
  logic [5:0]  pic_next;
  logic [6:0]  rpt_next;
  logic [20:0] rlen_next;

  assign cmd_ready = !result_valid || result_ready;
  assign load      = cmd_valid && cmd_ready;
  assign pad       = cmd.word[31:24];
  assign bits      = {cmd.rpsi_bytes, 3'b000};
  assign min_bits  = 22'd16 + {14'd0, pad};

  always_comb begin
    status_next = cmd.status;
    pid_next    = '0;
    blp_next    = '0;
    first_next  = '0;
    number_next = '0;
    pic_next    = '0;
    rpt_next    = '0;
    rlen_next   = '0;
    case (cmd.op)
      OP_NACK: begin
        pid_next = cmd.word[31:16];
        blp_next = cmd.word[15:0];
      end
      OP_SLI: begin
        first_next  = cmd.word[31:19];
        number_next = cmd.word[18:6];
        pic_next    = cmd.word[5:0];
      end
      OP_RPSI: begin
        if (pad >= 8'd32) begin
          status_next = ST_TOO_BIG;
        end else if ({1'b0, bits} < min_bits) begin
          status_next = ST_TOO_SMALL;
        end else begin
          status_next = ST_OK;
          rpt_next    = cmd.word[22:16];
          rlen_next   = bits - min_bits[20:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd_ready) begin
      result_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind              <= cmd.kind;
      status            <= status_next;
      entry_count       <= cmd.cnt;
      is_last           <= cmd.last;
      nack_pid          <= pid_next;
      nack_blp          <= blp_next;
      sli_first         <= first_next;
      sli_number        <= number_next;
      sli_picture_id    <= pic_next;
      rpsi_payload_type <= rpt_next;
      rpsi_bit_length   <= rlen_next;
    end
  end

endmodule
